// ===== src/xcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// xcbf_pkg
// Shared constants, types and the CRC-16 byte step for the block framer.
// ----------------------------------------------------------------------------
package xcbf_pkg;

   localparam int BLOCK_SIZE  = 128;
   localparam int POS_W       = $clog2(BLOCK_SIZE);
   localparam int MAX_RESULTS = 8;
   localparam int MAX_RUN     = 128;
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
   localparam int CMP_W       = POS_W + 8;

   localparam logic [7:0]  BYTE_SOH   = 8'h01;
   localparam logic [7:0]  BYTE_EOT   = 8'h04;
   localparam logic [7:0]  BYTE_ZERO  = 8'h00;
   localparam logic [7:0]  BYTE_ONES  = 8'hFF;
   localparam logic [7:0]  BLOCK_ONE  = 8'h01;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_INIT   = 16'h0000;

   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [POS_W:0]        posx_type;
   typedef logic [CMP_W-1:0]      cmp_type;
   typedef logic [3:0]            cnt_type;
   typedef logic [CMDQ_PTR_W-1:0] qptr_type;
   typedef logic [CMDQ_CNT_W-1:0] qcnt_type;

   // one classified payload byte, handed from the front to the back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        header;
      logic [7:0]  block_num;
      logic        close;
      pos_type     pad;
      logic        mode;
      logic [15:0] crc;
   } cmd_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  b);
      logic [15:0] c;
      c = crc_in ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== src/xcbf_front.sv =====
// ----------------------------------------------------------------------------
// xcbf_front
// Accepts payload bytes, tracks block position, number and data CRC, and
// classifies each byte into a command for the back end.
// ----------------------------------------------------------------------------
module xcbf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_data_byte,
   input  logic             req_last_byte,
   input  logic             csr_write_enable,
   input  logic             csr_framing_mode,
   input  logic             q_full,
   output logic             q_push,
   output xcbf_pkg::cmd_type q_cmd
);

   logic                 mode_ff,  mode_in;
   logic [7:0]           blk_ff,   blk_in;
   xcbf_pkg::pos_type    pos_ff,   pos_in;
   logic [15:0]          crc_ff,   crc_in;

   logic                 first;
   logic [15:0]          crc_new;
   xcbf_pkg::posx_type   pos_next;
   logic                 close;

   assign req_full = q_full;
   assign q_push   = req_push & ~q_full;

   always_comb begin
      first    = (pos_ff == '0);
      crc_new  = xcbf_pkg::crc_byte(first ? xcbf_pkg::CRC_INIT : crc_ff, req_data_byte);
      pos_next = {1'b0, pos_ff} + xcbf_pkg::posx_type'(1);
      close    = req_last_byte
               | (pos_next == xcbf_pkg::posx_type'(xcbf_pkg::BLOCK_SIZE));

      q_cmd.data_byte = req_data_byte;
      q_cmd.last_byte = req_last_byte;
      q_cmd.header    = first & mode_ff;
      q_cmd.block_num = blk_ff;
      q_cmd.close     = close;
      q_cmd.pad       = xcbf_pkg::pos_type'(
                           xcbf_pkg::posx_type'(xcbf_pkg::BLOCK_SIZE) - pos_next);
      q_cmd.mode      = mode_ff;
      q_cmd.crc       = crc_new;

      mode_in = csr_write_enable ? csr_framing_mode : mode_ff;
      blk_in  = blk_ff;
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      if (q_push) begin
         if (close) begin
            pos_in = '0;
            crc_in = xcbf_pkg::CRC_INIT;
            blk_in = req_last_byte ? xcbf_pkg::BLOCK_ONE : blk_ff + 8'd1;
         end else begin
            pos_in = pos_next[xcbf_pkg::POS_W-1:0];
            crc_in = crc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         blk_ff  <= xcbf_pkg::BLOCK_ONE;
         pos_ff  <= '0;
         crc_ff  <= xcbf_pkg::CRC_INIT;
      end else begin
         mode_ff <= mode_in;
         blk_ff  <= blk_in;
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
      end
   end

endmodule

// ===== src/xcbf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// xcbf_cmd_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module xcbf_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xcbf_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output xcbf_pkg::cmd_type head_cmd
);

   xcbf_pkg::cmd_type  entry_ff [xcbf_pkg::CMDQ_DEPTH];
   xcbf_pkg::qptr_type wr_ff, wr_in;
   xcbf_pkg::qptr_type rd_ff, rd_in;
   xcbf_pkg::qcnt_type cnt_ff, cnt_in;
   logic               do_push, do_pop;

   function automatic xcbf_pkg::qptr_type ptr_inc(input xcbf_pkg::qptr_type p);
      return (p == xcbf_pkg::qptr_type'(xcbf_pkg::CMDQ_DEPTH - 1))
             ? '0 : p + xcbf_pkg::qptr_type'(1);
   endfunction

   assign full     = (cnt_ff == xcbf_pkg::qcnt_type'(xcbf_pkg::CMDQ_DEPTH));
   assign valid    = (cnt_ff != '0);
   assign head_cmd = entry_ff[rd_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   always_comb begin
      wr_in  = do_push ? ptr_inc(wr_ff) : wr_ff;
      rd_in  = do_pop  ? ptr_inc(rd_ff) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + xcbf_pkg::qcnt_type'(1);
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - xcbf_pkg::qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/xcbf_back.sv =====
// ----------------------------------------------------------------------------
// xcbf_back
// Sequencer that expands one command into header, data, padding runs,
// CRC trailer and EOT, walking the CRC over the padding.
// ----------------------------------------------------------------------------
module xcbf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  xcbf_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic [7:0]        rsp_repeat_count,
   output logic              rsp_end_of_run,
   output logic              rsp_end_of_transfer
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_SOH  = 10'b00_0000_0010,
      ST_NUM  = 10'b00_0000_0100,
      ST_CPL  = 10'b00_0000_1000,
      ST_DATA = 10'b00_0001_0000,
      ST_WALK = 10'b00_0010_0000,
      ST_PAD  = 10'b00_0100_0000,
      ST_CRCH = 10'b00_1000_0000,
      ST_CRCL = 10'b01_0000_0000,
      ST_EOT  = 10'b10_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   xcbf_pkg::cmd_type  cmd_ff, cmd_in;
   logic [15:0]        crc_ff, crc_in;
   xcbf_pkg::pos_type  walk_ff, walk_in;
   xcbf_pkg::pos_type  pad_ff, pad_in;
   xcbf_pkg::cnt_type  n_ff, n_in;

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic [7:0]         out_rep_ff, out_rep_in;
   logic               out_eor_ff, out_eor_in;
   logic               out_eot_ff, out_eot_in;

   logic               slot_free;
   logic               emit;
   logic [7:0]         e_byte, e_rep;
   logic               e_last;
   xcbf_pkg::cnt_type  trailer;
   xcbf_pkg::cmp_type  pad_ext, run_ext;
   xcbf_pkg::pos_type  pad_rem;
   logic               pad_fits;
   state_type          after_data;

   assign rsp_empty           = ~out_valid_ff;
   assign rsp_out_byte        = out_byte_ff;
   assign rsp_repeat_count    = out_rep_ff;
   assign rsp_end_of_run      = out_eor_ff;
   assign rsp_end_of_transfer = out_eot_ff;

   assign slot_free = ~out_valid_ff | rsp_pop;
   assign cmd_pop   = cmd_valid & (state_ff == ST_IDLE);

   always_comb begin
      trailer  = cmd_ff.mode ? (cmd_ff.last_byte ? 4'd3 : 4'd2) : 4'd0;
      pad_ext  = xcbf_pkg::cmp_type'(pad_ff);
      run_ext  = (pad_ext > xcbf_pkg::cmp_type'(xcbf_pkg::MAX_RUN))
                 ? xcbf_pkg::cmp_type'(xcbf_pkg::MAX_RUN) : pad_ext;
      pad_rem  = xcbf_pkg::pos_type'(pad_ext - run_ext);
      pad_fits = (n_ff + trailer) < xcbf_pkg::cnt_type'(xcbf_pkg::MAX_RESULTS);

      if (!cmd_ff.close) begin
         after_data = ST_IDLE;
      end else if (cmd_ff.pad != '0) begin
         after_data = cmd_ff.mode ? ST_WALK : ST_PAD;
      end else begin
         after_data = cmd_ff.mode ? ST_CRCH : ST_IDLE;
      end

      state_in = state_ff;
      cmd_in   = cmd_ff;
      crc_in   = crc_ff;
      walk_in  = walk_ff;
      pad_in   = pad_ff;
      n_in     = n_ff;
      emit     = 1'b0;
      e_byte   = xcbf_pkg::BYTE_ZERO;
      e_rep    = 8'd1;
      e_last   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               crc_in   = cmd.crc;
               walk_in  = cmd.pad;
               pad_in   = cmd.pad;
               n_in     = '0;
               state_in = cmd.header ? ST_SOH : ST_DATA;
            end
         end
         ST_SOH: begin
            emit   = 1'b1;
            e_byte = xcbf_pkg::BYTE_SOH;
            if (slot_free) state_in = ST_NUM;
         end
         ST_NUM: begin
            emit   = 1'b1;
            e_byte = cmd_ff.block_num;
            if (slot_free) state_in = ST_CPL;
         end
         ST_CPL: begin
            emit   = 1'b1;
            e_byte = xcbf_pkg::BYTE_ONES - cmd_ff.block_num;
            if (slot_free) state_in = ST_DATA;
         end
         ST_DATA: begin
            emit   = 1'b1;
            e_byte = cmd_ff.data_byte;
            e_last = (after_data == ST_IDLE);
            if (slot_free) state_in = after_data;
         end
         ST_WALK: begin
            crc_in  = xcbf_pkg::crc_byte(crc_ff, xcbf_pkg::BYTE_ZERO);
            walk_in = walk_ff - xcbf_pkg::pos_type'(1);
            if (walk_ff == xcbf_pkg::pos_type'(1)) state_in = ST_PAD;
         end
         ST_PAD: begin
            emit   = pad_fits;
            e_byte = xcbf_pkg::BYTE_ZERO;
            e_rep  = run_ext[7:0];
            e_last = ~cmd_ff.mode
                   & ((pad_rem == '0)
                      | ((n_ff + xcbf_pkg::cnt_type'(1))
                         >= xcbf_pkg::cnt_type'(xcbf_pkg::MAX_RESULTS)));
            if (slot_free | ~pad_fits) begin
               pad_in = pad_rem;
               if (pad_rem == '0) state_in = cmd_ff.mode ? ST_CRCH : ST_IDLE;
            end
         end
         ST_CRCH: begin
            emit   = 1'b1;
            e_byte = crc_ff[15:8];
            if (slot_free) state_in = ST_CRCL;
         end
         ST_CRCL: begin
            emit   = 1'b1;
            e_byte = crc_ff[7:0];
            e_last = ~cmd_ff.last_byte;
            if (slot_free) state_in = cmd_ff.last_byte ? ST_EOT : ST_IDLE;
         end
         ST_EOT: begin
            emit   = 1'b1;
            e_byte = xcbf_pkg::BYTE_EOT;
            e_last = 1'b1;
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff & ~rsp_pop;
      out_byte_in  = out_byte_ff;
      out_rep_in   = out_rep_ff;
      out_eor_in   = out_eor_ff;
      out_eot_in   = out_eot_ff;
      if (emit & slot_free) begin
         out_valid_in = 1'b1;
         out_byte_in  = e_byte;
         out_rep_in   = e_rep;
         out_eor_in   = e_last;
         out_eot_in   = e_last & cmd_ff.last_byte;
         n_in         = n_ff + xcbf_pkg::cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      crc_ff      <= crc_in;
      walk_ff     <= walk_in;
      pad_ff      <= pad_in;
      n_ff        <= n_in;
      out_byte_ff <= out_byte_in;
      out_rep_ff  <= out_rep_in;
      out_eor_ff  <= out_eor_in;
      out_eot_ff  <= out_eot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== src/xmodem_crc_block_framer.sv =====
// ----------------------------------------------------------------------------
// xmodem_crc_block_framer
// Packs payload bytes into fixed-size blocks, raw or with XModem-CRC framing.
// ----------------------------------------------------------------------------
// Each payload transaction yields one or more result transactions: in
// XModem-CRC mode a block opens with SOH, number and complement, and the byte
// that closes a block adds its zero padding as one run, the CRC-16 (high byte
// first) and, on the final byte, EOT. The back end takes a command only in its
// idle state and emits that command's results one at a time, holding while the
// output register is still occupied. The byte that closes a block in XModem-CRC
// mode also walks the CRC over the padding one zero byte per cycle before its
// padding run goes out. A two-entry command queue lets the input run ahead of
// the back end.
// ----------------------------------------------------------------------------
module xmodem_crc_block_framer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_repeat_count,
   output logic       rsp_end_of_run,
   output logic       rsp_end_of_transfer,
   input  logic       csr_write_enable,
   input  logic       csr_framing_mode
);

   xcbf_pkg::cmd_type push_cmd;
   xcbf_pkg::cmd_type head_cmd;
   logic              q_push, q_full, q_valid, q_pop;

   xcbf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_framing_mode (csr_framing_mode),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (push_cmd)
   );

   xcbf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   xcbf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (q_valid),
      .cmd                 (head_cmd),
      .cmd_pop             (q_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_repeat_count    (rsp_repeat_count),
      .rsp_end_of_run      (rsp_end_of_run),
      .rsp_end_of_transfer (rsp_end_of_transfer)
   );

endmodule

// ===== src/xcbf_checker.sv =====
// ----------------------------------------------------------------------------
// xcbf_checker
// Port-level checks on the block framer, bound to the top level.
// ----------------------------------------------------------------------------
module xcbf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic [7:0] rsp_repeat_count,
   input logic       rsp_end_of_run,
   input logic       rsp_end_of_transfer
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not clear after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)
                                    && $stable(rsp_repeat_count)))
      else $error("waiting result changed");

   a_eot_ends_run: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_transfer) |-> rsp_end_of_run)
      else $error("end of transfer without end of run");

   a_repeat_zero_only: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_repeat_count != 8'd1) |->
         (rsp_out_byte == 8'h00 && rsp_repeat_count != 8'd0))
      else $error("bad repeat count");

endmodule

bind xmodem_crc_block_framer xcbf_checker u_xcbf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_full            (req_full),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_out_byte        (rsp_out_byte),
   .rsp_repeat_count    (rsp_repeat_count),
   .rsp_end_of_run      (rsp_end_of_run),
   .rsp_end_of_transfer (rsp_end_of_transfer)
);

// ===== tb/xmodem_crc_block_framer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xmodem_crc_block_framer_tb
// Self-checking bench for the XModem-CRC block framer.
// ----------------------------------------------------------------------------
// Payload bytes are pushed from a backlog through a randomly stalling driver.
// Every accepted byte is run through a local framing model (header, padding
// run, CRC-16 trailer, EOT) and the link transactions it should produce are
// queued. A randomly stalling monitor pops the link side and compares each
// transaction field by field with the oldest one queued. The framing mode is
// changed only with the link drained, often with a block left open, so the
// mode switches inside blocks.
// ----------------------------------------------------------------------------
module xmodem_crc_block_framer_tb;

   typedef struct {
      logic [7:0] data_byte;
      logic       last_byte;
   } payload_item_type;

   typedef struct {
      logic [7:0] out_byte;
      logic [7:0] repeat_count;
      logic       end_of_run;
      logic       end_of_transfer;
   } link_result_type;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_repeat_count;
   logic       rsp_end_of_run;
   logic       rsp_end_of_transfer;
   logic       csr_write_enable;
   logic       csr_framing_mode;

   payload_item_type tx_backlog[$];
   link_result_type  link_bytes_due[$];
   link_result_type  burst[$];
   payload_item_type next_item;
   link_result_type  want;

   logic       frame_mode;
   logic [7:0] frame_block_no;
   int         frame_fill;
   logic [15:0] frame_crc;

   int send_idle_pct;
   int recv_idle_pct;
   int errors;

   xmodem_crc_block_framer dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_data_byte       (req_data_byte),
      .req_last_byte       (req_last_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_repeat_count    (rsp_repeat_count),
      .rsp_end_of_run      (rsp_end_of_run),
      .rsp_end_of_transfer (rsp_end_of_transfer),
      .csr_write_enable    (csr_write_enable),
      .csr_framing_mode    (csr_framing_mode)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // framing model
   // ------------------------------------------------------------------
   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ d[i];
         r  = {r[14:0], 1'b0} ^ (fb ? xcbf_pkg::CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic void stage_result(input logic [7:0] b, input int rep);
      link_result_type r;
      if (burst.size() < xcbf_pkg::MAX_RESULTS) begin
         r.out_byte        = b;
         r.repeat_count    = rep[7:0];
         r.end_of_run      = 1'b0;
         r.end_of_transfer = 1'b0;
         burst.push_back(r);
      end
   endfunction

   function automatic void frame_payload_byte(input logic [7:0] b, input logic last);
      int pad;
      int run_len;
      int trailer;
      burst.delete();
      if (frame_fill >= xcbf_pkg::BLOCK_SIZE)
         frame_fill = 0;
      if (frame_fill == 0) begin
         frame_crc = xcbf_pkg::CRC_INIT;
         if (frame_mode) begin
            stage_result(xcbf_pkg::BYTE_SOH, 1);
            stage_result(frame_block_no, 1);
            stage_result(xcbf_pkg::BYTE_ONES - frame_block_no, 1);
         end
      end
      stage_result(b, 1);
      frame_crc = crc16_step(frame_crc, b);
      frame_fill++;
      if (last || frame_fill >= xcbf_pkg::BLOCK_SIZE) begin
         pad     = xcbf_pkg::BLOCK_SIZE - frame_fill;
         trailer = frame_mode ? (last ? 3 : 2) : 0;
         for (int k = 0; k < pad; k++)
            frame_crc = crc16_step(frame_crc, xcbf_pkg::BYTE_ZERO);
         while (pad > 0) begin
            run_len = (pad > xcbf_pkg::MAX_RUN) ? xcbf_pkg::MAX_RUN : pad;
            if (burst.size() + trailer < xcbf_pkg::MAX_RESULTS)
               stage_result(xcbf_pkg::BYTE_ZERO, run_len);
            pad -= run_len;
         end
         if (frame_mode) begin
            stage_result(frame_crc[15:8], 1);
            stage_result(frame_crc[7:0], 1);
            if (last)
               stage_result(xcbf_pkg::BYTE_EOT, 1);
         end
         frame_fill     = 0;
         frame_crc      = xcbf_pkg::CRC_INIT;
         frame_block_no = frame_block_no + 8'd1;
         if (last)
            frame_block_no = xcbf_pkg::BLOCK_ONE;
      end
      burst[burst.size()-1].end_of_run = 1'b1;
      if (last)
         burst[burst.size()-1].end_of_transfer = 1'b1;
      foreach (burst[i])
         link_bytes_due.push_back(burst[i]);
   endfunction

   // ------------------------------------------------------------------
   // driver and monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            frame_payload_byte(req_data_byte, req_last_byte);
         if (!req_push || !req_full) begin
            if (tx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = tx_backlog.pop_front();
               req_push      <= 1'b1;
               req_data_byte <= next_item.data_byte;
               req_last_byte <= next_item.last_byte;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   task automatic flag_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (link_bytes_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected transaction, byte %02h count %0d",
                                       rsp_out_byte, rsp_repeat_count));
            end else begin
               want = link_bytes_due.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  flag_mismatch($sformatf("out_byte %02h, wanted %02h",
                                          rsp_out_byte, want.out_byte));
               if (rsp_repeat_count !== want.repeat_count)
                  flag_mismatch($sformatf("repeat_count %0d, wanted %0d",
                                          rsp_repeat_count, want.repeat_count));
               if (rsp_end_of_run !== want.end_of_run)
                  flag_mismatch($sformatf("end_of_run %b, wanted %b",
                                          rsp_end_of_run, want.end_of_run));
               if (rsp_end_of_transfer !== want.end_of_transfer)
                  flag_mismatch($sformatf("end_of_transfer %b, wanted %b",
                                          rsp_end_of_transfer, want.end_of_transfer));
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   function automatic void queue_item(input logic [7:0] b, input logic last);
      payload_item_type it;
      it.data_byte = b;
      it.last_byte = last;
      tx_backlog.push_back(it);
   endfunction

   function automatic void queue_transfer(input int len, input bit close);
      for (int i = 0; i < len; i++)
         queue_item(8'($urandom_range(255)), close && (i == len - 1));
   endfunction

   // mostly short transfers, some longer ones.
   // The final transfer is sometimes left open so the next mode catches it mid-block.
   function automatic void queue_random_traffic(input int target);
      int  count;
      int  len;
      int  r;
      bit  close;
      count = 0;
      while (count < target) begin
         r = $urandom_range(99);
         if (r < 75)
            len = $urandom_range(12, 1);
         else
            len = $urandom_range(40, 13);
         count += len;
         close = (count < target) || $urandom_range(1);
         queue_transfer(len, close);
      end
   endfunction

   task automatic drain_link();
      @(negedge clock);
      while (tx_backlog.size() != 0 || req_push || link_bytes_due.size() != 0)
         @(negedge clock);
      repeat (xcbf_pkg::BLOCK_SIZE + 8) @(posedge clock);
   endtask

   task automatic write_framing_mode(input logic m);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_framing_mode <= m;
      frame_mode = m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_push         = 1'b0;
      req_data_byte    = 8'h00;
      req_last_byte    = 1'b0;
      rsp_pop          = 1'b0;
      csr_write_enable = 1'b0;
      csr_framing_mode = 1'b0;
      frame_mode       = 1'b0;
      frame_block_no   = xcbf_pkg::BLOCK_ONE;
      frame_fill       = 0;
      frame_crc        = xcbf_pkg::CRC_INIT;
      errors           = 0;
      send_idle_pct    = 32;
      recv_idle_pct    = 63;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // raw mode out of reset: lone byte, then a block left open
      queue_item(8'h00, 1'b1);
      queue_item(8'hFF, 1'b0);
      queue_item(8'hA5, 1'b0);
      drain_link();

      // open raw block closed under framing, a single-byte framed transfer, then a block left open
      write_framing_mode(1'b1);
      queue_item(8'h5A, 1'b1);
      queue_item(8'h00, 1'b1);
      queue_item(8'hFF, 1'b0);
      queue_item(8'h80, 1'b0);
      queue_item(8'h01, 1'b0);
      drain_link();

      // framed block closed in raw mode, then a two-byte raw transfer
      write_framing_mode(1'b0);
      queue_item(8'h7F, 1'b1);
      queue_item(8'h55, 1'b0);
      queue_item(8'hAA, 1'b1);
      drain_link();

      write_framing_mode(1'b1);
      queue_item(8'hC3, 1'b0);
      queue_item(8'h3C, 1'b1);
      queue_random_traffic(28);
      drain_link();

      send_idle_pct = 63;
      recv_idle_pct = 32;
      write_framing_mode(1'b0);
      queue_random_traffic(28);
      drain_link();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_framing_mode(1'b1);
      queue_random_traffic(28);
      drain_link();

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
